@@ rtl/core/fpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// fpcd_pkg
// shared types and constants of the fence pulse code detector
// ----------------------------------------------------------------------------
`default_nettype none

package fpcd_pkg;

    // input item
    typedef struct packed {
        logic        opcode;
        logic [31:0] now_us;
    } t_in;

    // result item
    typedef struct packed {
        logic [1:0] current_sensor;
        logic [1:0] status_s0;
        logic [1:0] status_s1;
        logic [1:0] status_s2;
        logic [1:0] status_s3;
        logic [7:0] pulse_units;
        logic [1:0] match_kind;
        logic       timed_out;
        logic       signal_lost;
    } t_out;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       load;
        logic       div_step;
        logic [2:0] div_bit;
        logic       match;
        logic       rotate;
        logic       finish;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_edge;
        logic out_free;
    } t_sts;

    // opcodes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // signal codes
    localparam logic [1:0] SIG_NONE    = 2'd0;
    localparam logic [1:0] SIG_INSIDE  = 2'd1;
    localparam logic [1:0] SIG_OUTSIDE = 2'd2;

    // config register indexes
    localparam logic [2:0] CFG_INSIDE_UNITS   = 3'd0;
    localparam logic [2:0] CFG_OUTSIDE_UNITS  = 3'd1;
    localparam logic [2:0] CFG_UNIT_LENGTH_US = 3'd2;
    localparam logic [2:0] CFG_COLLECT_TIME   = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT        = 3'd4;
    localparam logic [2:0] CFG_NO_SIGNAL      = 3'd5;
    localparam logic [2:0] CFG_MANUAL_MODE    = 3'd6;
    localparam logic [2:0] CFG_MANUAL_SENSOR  = 3'd7;

    // config reset values
    localparam logic [7:0]  RST_INSIDE_UNITS   = 8'd85;
    localparam logic [7:0]  RST_OUTSIDE_UNITS  = 8'd38;
    localparam logic [15:0] RST_UNIT_LENGTH_US = 16'd100;
    localparam logic [31:0] RST_COLLECT_TIME   = 32'd200000;
    localparam logic [31:0] RST_TIMEOUT        = 32'd10000000;
    localparam logic [31:0] RST_NO_SIGNAL      = 32'd2000000;

    // code positions at which a code completes
    localparam logic       INSIDE_LAST_POS  = 1'b1;
    localparam logic [1:0] OUTSIDE_LAST_POS = 2'd3;

    // quotient is built msb first, starting from this bit
    localparam logic [2:0] DIV_TOP_BIT = 3'd7;
    localparam logic [7:0] UNITS_MAX   = 8'hFF;

    // status slots on the result, fixed by the output fields
    localparam int SENSOR_SLOTS = 4;

endpackage

`default_nettype wire

@@ rtl/core/fpcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpcd_ctrl
// sequencer: capture, load, eight divide steps, match, rotate, finish; a poll goes from load to finish
// ----------------------------------------------------------------------------
`default_nettype none

module fpcd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_stall,
    input  wire fpcd_pkg::t_sts i_sts,
    output      fpcd_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOAD   = 6'b000010,
        S_DIV    = 6'b000100,
        S_MATCH  = 6'b001000,
        S_ROTATE = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_bit           = r_bit;
        o_cmd           = '0;
        o_cmd.div_bit   = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_bit      = fpcd_pkg::DIV_TOP_BIT;
                n_state    = i_sts.is_edge ? S_DIV : S_FINISH;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_bit == 3'd0) begin
                    n_state = S_MATCH;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_ROTATE;
            end
            S_ROTATE: begin
                o_cmd.rotate = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/core/fpcd_datapath.sv @@
// ----------------------------------------------------------------------------
// fpcd_datapath
// config registers, detection state, serial divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fpcd_datapath #(
    parameter int SENSOR_COUNT = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data,
    input  wire fpcd_pkg::t_in  i_in_data,
    output      logic           o_out_valid,
    input  wire logic           i_out_stall,
    output      fpcd_pkg::t_out o_out_data,
    input  wire fpcd_pkg::t_cmd i_cmd,
    output      fpcd_pkg::t_sts o_sts
);

    localparam logic [1:0] LAST_SENSOR = 2'(SENSOR_COUNT - 1);

    // config
    logic [7:0]  r_inside_units, r_outside_units;
    logic [15:0] r_unit_len;
    logic [31:0] r_collect, r_timeout, r_no_signal;
    logic        r_manual_mode;
    logic [1:0]  r_manual_sensor;

    // detection state
    logic [31:0] r_last_edge, n_last_edge;
    logic [31:0] r_last_switch, n_last_switch;
    logic [31:0] r_last_match, n_last_match;
    logic        r_ipos, n_ipos;
    logic [1:0]  r_opos, n_opos;
    logic [1:0]  r_signal, n_signal;
    logic [1:0]  r_sel, n_sel;
    logic [1:0]  r_sensor_state [fpcd_pkg::SENSOR_SLOTS];
    logic [1:0]  n_sensor_state [fpcd_pkg::SENSOR_SLOTS];

    // per transaction working registers
    logic        r_opcode, n_opcode;
    logic [31:0] r_now, n_now;
    logic [32:0] r_num, n_num;
    logic [7:0]  r_quot, n_quot;
    logic        r_sat, n_sat;
    logic [7:0]  r_units, n_units;
    logic [1:0]  r_kind, n_kind;
    logic        r_out_valid, n_out_valid;
    fpcd_pkg::t_out r_out, n_out;

    // combinational terms
    logic [1:0]  w_manual_pick, w_next;
    logic [31:0] w_diff, w_since_switch, w_since_match;
    logic [32:0] w_sum, w_limit, w_trial;
    logic [7:0]  w_units;
    logic [9:0]  w_d_in, w_out_exp, w_d_out;
    logic        w_near_in, w_near_out;

    assign w_manual_pick  = (r_manual_sensor > LAST_SENSOR) ? LAST_SENSOR : r_manual_sensor;
    assign w_next         = (r_sel == LAST_SENSOR) ? 2'd0 : r_sel + 2'd1;
    assign w_diff         = r_now - r_last_edge;
    assign w_since_switch = r_now - r_last_switch;
    assign w_since_match  = r_now - r_last_match;
    assign w_sum          = {1'b0, w_diff} + {18'd0, r_unit_len[15:1]};
    assign w_limit        = {9'd0, r_unit_len, 8'h00};
    assign w_trial        = {17'd0, r_unit_len} << i_cmd.div_bit;
    assign w_units        = r_sat ? fpcd_pkg::UNITS_MAX : r_quot;

    // distance to the expected code, within one unit counts as a hit
    assign w_d_in     = {2'b00, w_units} - {2'b00, r_inside_units};
    assign w_out_exp  = r_opos[0] ? ({2'b00, r_inside_units} - {2'b00, r_outside_units})
                                  : {2'b00, r_outside_units};
    assign w_d_out    = {2'b00, w_units} - w_out_exp;
    assign w_near_in  = (w_d_in == 10'h000) || (w_d_in == 10'h001) || (w_d_in == 10'h3FF);
    assign w_near_out = (w_d_out == 10'h000) || (w_d_out == 10'h001) || (w_d_out == 10'h3FF);

    assign o_sts.is_edge  = (r_opcode == fpcd_pkg::OP_EDGE);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_last_edge    = r_last_edge;
        n_last_switch  = r_last_switch;
        n_last_match   = r_last_match;
        n_ipos         = r_ipos;
        n_opos         = r_opos;
        n_signal       = r_signal;
        n_sel          = r_sel;
        n_sensor_state = r_sensor_state;
        n_opcode       = r_opcode;
        n_now          = r_now;
        n_num          = r_num;
        n_quot         = r_quot;
        n_sat          = r_sat;
        n_units        = r_units;
        n_kind         = r_kind;
        n_out          = r_out;
        n_out_valid    = r_out_valid && i_out_stall;

        if (i_cmd.capture) begin
            n_opcode = i_in_data.opcode;
            n_now    = i_in_data.now_us;
        end

        if (i_cmd.load) begin
            n_units = 8'd0;
            n_kind  = 2'd0;
            if (r_manual_mode && (w_manual_pick != r_sel)) begin
                n_sel         = w_manual_pick;
                n_signal      = fpcd_pkg::SIG_NONE;
                n_ipos        = 1'b0;
                n_opos        = 2'd0;
                n_last_switch = r_now;
            end
            if (r_opcode == fpcd_pkg::OP_EDGE) begin
                n_last_edge = r_now;
                n_num       = w_sum;
                n_quot      = 8'd0;
                // rounded quotient above 255, or zero unit length
                n_sat       = (r_unit_len == 16'd0) || (w_sum >= w_limit);
            end
        end

        // restoring divide, one quotient bit per step
        if (i_cmd.div_step && (r_num >= w_trial)) begin
            n_num                 = r_num - w_trial;
            n_quot[i_cmd.div_bit] = 1'b1;
        end

        if (i_cmd.match) begin
            n_units = w_units;
            n_kind  = 2'd0;
            if (w_near_in) begin
                if (r_ipos == fpcd_pkg::INSIDE_LAST_POS) begin
                    n_signal              = fpcd_pkg::SIG_INSIDE;
                    n_sensor_state[r_sel] = fpcd_pkg::SIG_INSIDE;
                    n_last_match          = r_now;
                    n_ipos                = 1'b0;
                    n_kind[0]             = 1'b1;
                end else begin
                    n_ipos = 1'b1;
                end
            end else begin
                n_ipos = 1'b0;
            end
            // outside overrides inside when both complete
            if (w_near_out) begin
                if (r_opos == fpcd_pkg::OUTSIDE_LAST_POS) begin
                    n_signal              = fpcd_pkg::SIG_OUTSIDE;
                    n_sensor_state[r_sel] = fpcd_pkg::SIG_OUTSIDE;
                    n_last_match          = r_now;
                    n_opos                = 2'd0;
                    n_kind[1]             = 1'b1;
                end else begin
                    n_opos = r_opos + 2'd1;
                end
            end else begin
                n_opos = 2'd0;
            end
        end

        if (i_cmd.rotate && !r_manual_mode) begin
            if ((r_signal != fpcd_pkg::SIG_NONE) || (w_since_switch > r_collect)) begin
                if (r_signal == fpcd_pkg::SIG_NONE) begin
                    n_sensor_state[r_sel] = fpcd_pkg::SIG_NONE;
                end
                if (w_next != r_sel) begin
                    n_sel         = w_next;
                    n_signal      = fpcd_pkg::SIG_NONE;
                    n_ipos        = 1'b0;
                    n_opos        = 2'd0;
                    n_last_switch = r_now;
                end
            end
        end

        if (i_cmd.finish) begin
            n_out_valid          = 1'b1;
            n_out.current_sensor = r_sel;
            n_out.status_s0      = r_sensor_state[0];
            n_out.status_s1      = r_sensor_state[1];
            n_out.status_s2      = r_sensor_state[2];
            n_out.status_s3      = r_sensor_state[3];
            n_out.pulse_units    = r_units;
            n_out.match_kind     = r_kind;
            n_out.timed_out      = (w_since_match > r_timeout);
            n_out.signal_lost    = (w_since_match > r_no_signal);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_units  <= fpcd_pkg::RST_INSIDE_UNITS;
            r_outside_units <= fpcd_pkg::RST_OUTSIDE_UNITS;
            r_unit_len      <= fpcd_pkg::RST_UNIT_LENGTH_US;
            r_collect       <= fpcd_pkg::RST_COLLECT_TIME;
            r_timeout       <= fpcd_pkg::RST_TIMEOUT;
            r_no_signal     <= fpcd_pkg::RST_NO_SIGNAL;
            r_manual_mode   <= 1'b0;
            r_manual_sensor <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fpcd_pkg::CFG_INSIDE_UNITS:   r_inside_units  <= i_cfg_data[7:0];
                fpcd_pkg::CFG_OUTSIDE_UNITS:  r_outside_units <= i_cfg_data[7:0];
                fpcd_pkg::CFG_UNIT_LENGTH_US: r_unit_len      <= i_cfg_data[15:0];
                fpcd_pkg::CFG_COLLECT_TIME:   r_collect       <= i_cfg_data;
                fpcd_pkg::CFG_TIMEOUT:        r_timeout       <= i_cfg_data;
                fpcd_pkg::CFG_NO_SIGNAL:      r_no_signal     <= i_cfg_data;
                fpcd_pkg::CFG_MANUAL_MODE:    r_manual_mode   <= i_cfg_data[0];
                fpcd_pkg::CFG_MANUAL_SENSOR:  r_manual_sensor <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge    <= 32'd0;
            r_last_switch  <= 32'd0;
            r_last_match   <= 32'd0;
            r_ipos         <= 1'b0;
            r_opos         <= 2'd0;
            r_signal       <= fpcd_pkg::SIG_NONE;
            r_sel          <= 2'd0;
            r_sensor_state <= '{default: fpcd_pkg::SIG_NONE};
            r_out_valid    <= 1'b0;
        end else begin
            r_last_edge    <= n_last_edge;
            r_last_switch  <= n_last_switch;
            r_last_match   <= n_last_match;
            r_ipos         <= n_ipos;
            r_opos         <= n_opos;
            r_signal       <= n_signal;
            r_sel          <= n_sel;
            r_sensor_state <= n_sensor_state;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode <= n_opcode;
        r_now    <= n_now;
        r_num    <= n_num;
        r_quot   <= n_quot;
        r_sat    <= n_sat;
        r_units  <= n_units;
        r_kind   <= n_kind;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ rtl/core/fence_pulse_code_detector.sv @@
// ----------------------------------------------------------------------------
// fence_pulse_code_detector
// decodes inside/outside pulse codes of up to four multiplexed fence sensors
// ----------------------------------------------------------------------------
// Each input transaction is an edge event or a status poll with a 32-bit
// microsecond timestamp, and each one returns exactly one result transaction.
// An edge rounds the time since the previous edge to pulse units (saturating
// at 255), checks it within one unit against the inside code {I,I} and the
// outside code {O,I-O,O,I-O}, records a completed code as the status of the
// selected sensor, and moves on to the next sensor after a match or after
// collect_time_us without one (marking that sensor no-signal). Manual mode
// pins the sensor named by manual_sensor. One transaction is processed at a
// time: an edge runs load, the 8-step restoring divider (one pulse count bit
// per cycle), match, rotate, finish; a poll only load and finish. A finished
// result sits in the output register, so a stalled output holds only the
// finish state. Configuration is written through a plain write port; the user
// must write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module fence_pulse_code_detector #(
    parameter int SENSOR_COUNT = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // config write port
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data,
    // input channel
    input  wire logic           i_in_valid,
    output      logic           o_in_stall,
    input  wire fpcd_pkg::t_in  i_in_data,
    // result channel
    output      logic           o_out_valid,
    input  wire logic           i_out_stall,
    output      fpcd_pkg::t_out o_out_data
);

    // controller to datapath handshake
    fpcd_pkg::t_cmd w_cmd;
    fpcd_pkg::t_sts w_sts;

    // sequencer: steps each edge through load, divide, match, rotate and finish, a poll through load and finish
    fpcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // all arithmetic, detection state and the result register
    fpcd_datapath #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

`default_nettype wire

@@ rtl/core/fpcd_checker.sv @@
// ----------------------------------------------------------------------------
// fpcd_checker
// port level checks of the fence pulse code detector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fpcd_checker #(
    parameter int SENSOR_COUNT = 4
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire fpcd_pkg::t_out o_out_data
);

    localparam logic [1:0] LAST_SENSOR = 2'(SENSOR_COUNT - 1);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one transaction at a time: input is blocked right after an accept
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a transaction is in flight");

    // selected sensor in range and no invalid status codes
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.current_sensor <= LAST_SENSOR)
            && (o_out_data.status_s0 != 2'd3) && (o_out_data.status_s1 != 2'd3)
            && (o_out_data.status_s2 != 2'd3) && (o_out_data.status_s3 != 2'd3))
        else $error("sensor select or status code out of range");

    // a match on this edge restarts the timeout, so no flag can be up
    a_match_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.match_kind != 2'd0)
            |-> !o_out_data.timed_out && !o_out_data.signal_lost)
        else $error("timeout flag set on a matching edge");

endmodule

bind fence_pulse_code_detector fpcd_checker #(
    .SENSOR_COUNT (SENSOR_COUNT)
) u_fpcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fence pulse code detector
// ----------------------------------------------------------------------------
// A directed table comes first: reset values, both code patterns, tolerance
// edges, a collect timeout, manual mode with both codes finishing together,
// zero unit length and timestamp wrap. Random phases follow, each with its own
// register setting, the extremes among them. Edge intervals are built mostly
// from whole inside and outside code sequences with jitter, mixed with noise,
// long gaps and polls. Every result transaction is checked field by field
// against an in-bench model of the detector or a fixed expected value.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int SENSORS      = 4;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int STUCK_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    // marker in the pulse plan for a long gap, usually past the collect time
    localparam int LONG_GAP     = -100000;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_cfg_we    = 1'b0;
    logic [2:0]     i_cfg_index = fpcd_pkg::CFG_INSIDE_UNITS;
    logic [31:0]    i_cfg_data  = '0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_stall;
    fpcd_pkg::t_in  i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    fpcd_pkg::t_out o_out_data;

    fence_pulse_code_detector #(
        .SENSOR_COUNT(SENSORS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // detector model: register copies and decode state
    // ------------------------------------------------------------------------
    logic [7:0]  inside_u;
    logic [7:0]  outside_u;
    logic [15:0] unit_len;
    logic [31:0] collect_us;
    logic [31:0] timeout_lim;
    logic [31:0] no_sig_lim;
    logic        manual_on;
    logic [1:0]  manual_pick;

    logic [31:0] last_edge_at;
    logic [31:0] last_switch_at;
    logic [31:0] last_match_at;
    logic        inside_pos;
    logic [1:0]  outside_pos;
    logic [1:0]  live_signal;
    logic [1:0]  sel_sensor;
    logic [1:0]  sensor_status [SENSORS];

    // expected result transactions, oldest first
    fpcd_pkg::t_out pending_reports[$];

    bit failed    = 1'b0;
    bit in_idle   = 1'b1;
    bit out_idle  = 1'b1;
    int stall_left = 0;
    int stuck_cycles = 0;

    // directed rows: a register write or an input transaction
    typedef struct {
        bit             is_reg;
        logic [2:0]     reg_idx;
        logic [31:0]    reg_val;
        fpcd_pkg::t_in  it;
        bit             typed;
        fpcd_pkg::t_out known;
    } t_plan_row;

    t_plan_row directed_plan[$];

    function automatic void plan_item(bit typed, logic op, logic [31:0] at,
                                      fpcd_pkg::t_out known);
        t_plan_row r;
        r.is_reg    = 1'b0;
        r.reg_idx   = fpcd_pkg::CFG_INSIDE_UNITS;
        r.reg_val   = '0;
        r.it.opcode = op;
        r.it.now_us = at;
        r.typed     = typed;
        r.known     = known;
        directed_plan.push_back(r);
    endfunction

    function automatic void plan_reg(logic [2:0] idx, logic [31:0] val);
        t_plan_row r;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.it      = '0;
        r.typed   = 1'b0;
        r.known   = '0;
        directed_plan.push_back(r);
    endfunction

    // switching sensors drops the live signal and restarts both codes
    function automatic void select_sensor(logic [1:0] n, logic [31:0] at);
        if (n != sel_sensor) begin
            sel_sensor     = n;
            live_signal    = fpcd_pkg::SIG_NONE;
            inside_pos     = 1'b0;
            outside_pos    = 2'd0;
            last_switch_at = at;
        end
    endfunction

    function automatic bit within_one(int units, int code);
        return (units - code > -2) && (units - code < 2);
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            fpcd_pkg::CFG_INSIDE_UNITS:   inside_u    = val[7:0];
            fpcd_pkg::CFG_OUTSIDE_UNITS:  outside_u   = val[7:0];
            fpcd_pkg::CFG_UNIT_LENGTH_US: unit_len    = val[15:0];
            fpcd_pkg::CFG_COLLECT_TIME:   collect_us  = val;
            fpcd_pkg::CFG_TIMEOUT:        timeout_lim = val;
            fpcd_pkg::CFG_NO_SIGNAL:      no_sig_lim  = val;
            fpcd_pkg::CFG_MANUAL_MODE:    manual_on   = val[0];
            fpcd_pkg::CFG_MANUAL_SENSOR:  manual_pick = val[1:0];
            default: ;
        endcase
    endfunction

    // one step of the detector: updates the model state, returns the report
    function automatic fpcd_pkg::t_out detect_step(fpcd_pkg::t_in it);
        fpcd_pkg::t_out   r;
        logic [31:0]      since_edge;
        logic [31:0]      since_switch;
        logic [31:0]      since_match;
        longint unsigned  q;
        int               step_code;
        logic [1:0]       pin;
        logic [1:0]       next_s;
        r = '0;
        if (manual_on) begin
            pin = (int'(manual_pick) >= SENSORS) ? 2'(SENSORS - 1) : manual_pick;
            select_sensor(pin, it.now_us);
        end
        if (it.opcode == fpcd_pkg::OP_EDGE) begin
            since_edge   = it.now_us - last_edge_at;
            last_edge_at = it.now_us;
            // round to pulse units, saturating; zero unit length saturates
            if (unit_len == 16'd0) begin
                r.pulse_units = fpcd_pkg::UNITS_MAX;
            end else begin
                q = ({32'd0, since_edge} + 64'(unit_len >> 1)) / 64'(unit_len);
                r.pulse_units = (q > 64'd255) ? fpcd_pkg::UNITS_MAX : q[7:0];
            end
            // inside code {I,I}
            if (within_one(int'(r.pulse_units), int'(inside_u))) begin
                if (inside_pos == fpcd_pkg::INSIDE_LAST_POS) begin
                    inside_pos                 = 1'b0;
                    live_signal                = fpcd_pkg::SIG_INSIDE;
                    sensor_status[sel_sensor]  = fpcd_pkg::SIG_INSIDE;
                    last_match_at              = it.now_us;
                    r.match_kind[0]            = 1'b1;
                end else begin
                    inside_pos = 1'b1;
                end
            end else begin
                inside_pos = 1'b0;
            end
            // outside code {O,I-O,O,I-O}; I-O may go negative, and at -1 it still matches a zero pulse
            step_code = outside_pos[0] ? int'(inside_u) - int'(outside_u) : int'(outside_u);
            if (within_one(int'(r.pulse_units), step_code)) begin
                if (outside_pos == fpcd_pkg::OUTSIDE_LAST_POS) begin
                    outside_pos                = 2'd0;
                    live_signal                = fpcd_pkg::SIG_OUTSIDE;
                    sensor_status[sel_sensor]  = fpcd_pkg::SIG_OUTSIDE;
                    last_match_at              = it.now_us;
                    r.match_kind[1]            = 1'b1;
                end else begin
                    outside_pos = outside_pos + 2'd1;
                end
            end else begin
                outside_pos = 2'd0;
            end
            // rotation: after a match, or after the collect time with none
            if (!manual_on) begin
                next_s       = 2'((int'(sel_sensor) + 1) % SENSORS);
                since_switch = it.now_us - last_switch_at;
                if (live_signal != fpcd_pkg::SIG_NONE) begin
                    select_sensor(next_s, it.now_us);
                end else if (since_switch > collect_us) begin
                    sensor_status[sel_sensor] = fpcd_pkg::SIG_NONE;
                    select_sensor(next_s, it.now_us);
                end
            end
        end
        r.current_sensor = sel_sensor;
        r.status_s0      = sensor_status[0];
        r.status_s1      = sensor_status[1];
        r.status_s2      = sensor_status[2];
        r.status_s3      = sensor_status[3];
        since_match      = it.now_us - last_match_at;
        r.timed_out      = since_match > timeout_lim;
        r.signal_lost    = since_match > no_sig_lim;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r = int'($urandom_range(0, 99));
        if (r < 80) return int'($urandom_range(1, 3));
        if (r < 95) return int'($urandom_range(4, 14));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failed = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------
    // offer one transaction, hold it until taken, then maybe idle a while
    task automatic push_item(fpcd_pkg::t_in it, bit typed, fpcd_pkg::t_out known);
        fpcd_pkg::t_out want;
        int             gap;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = detect_step(it);
        pending_reports.push_back(typed ? known : want);
        gap = (in_idle && $urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait until every expected report is in and the block sits idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, val);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: check each accepted report, stall at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        fpcd_pkg::t_out want;
        if (o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $error("result transaction with no expected report");
                failed = 1'b1;
            end else begin
                want = pending_reports.pop_front();
                compare_field("current_sensor", 32'(want.current_sensor),
                              32'(o_out_data.current_sensor));
                compare_field("status_s0", 32'(want.status_s0),
                              32'(o_out_data.status_s0));
                compare_field("status_s1", 32'(want.status_s1),
                              32'(o_out_data.status_s1));
                compare_field("status_s2", 32'(want.status_s2),
                              32'(o_out_data.status_s2));
                compare_field("status_s3", 32'(want.status_s3),
                              32'(o_out_data.status_s3));
                compare_field("pulse_units", 32'(want.pulse_units),
                              32'(o_out_data.pulse_units));
                compare_field("match_kind", 32'(want.match_kind),
                              32'(o_out_data.match_kind));
                compare_field("timed_out", 32'(want.timed_out),
                              32'(o_out_data.timed_out));
                compare_field("signal_lost", 32'(want.signal_lost),
                              32'(o_out_data.signal_lost));
            end
        end
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (out_idle && $urandom_range(0, 99) < 25) begin
            stall_left  = gap_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        fpcd_pkg::t_out quiet;
        fpcd_pkg::t_out overdue;
        fpcd_pkg::t_in  item;
        logic [31:0]    stamp;
        logic [7:0]     ins;
        logic [7:0]     outs;
        logic [15:0]    ulen;
        logic [31:0]    coll;
        logic [31:0]    tmo;
        logic [31:0]    nsig;
        logic           man;
        logic [1:0]     mpick;
        int             span;
        int             pick;
        int             units;
        longint         diff;
        int             pulse_plan[$];

        // model state after reset
        inside_u       = fpcd_pkg::RST_INSIDE_UNITS;
        outside_u      = fpcd_pkg::RST_OUTSIDE_UNITS;
        unit_len       = fpcd_pkg::RST_UNIT_LENGTH_US;
        collect_us     = fpcd_pkg::RST_COLLECT_TIME;
        timeout_lim    = fpcd_pkg::RST_TIMEOUT;
        no_sig_lim     = fpcd_pkg::RST_NO_SIGNAL;
        manual_on      = 1'b0;
        manual_pick    = 2'd0;
        last_edge_at   = '0;
        last_switch_at = '0;
        last_match_at  = '0;
        inside_pos     = 1'b0;
        outside_pos    = 2'd0;
        live_signal    = fpcd_pkg::SIG_NONE;
        sel_sensor     = 2'd0;
        foreach (sensor_status[s]) sensor_status[s] = fpcd_pkg::SIG_NONE;

        quiet               = '0;
        overdue             = '0;
        overdue.timed_out   = 1'b1;
        overdue.signal_lost = 1'b1;

        // fresh after reset: nothing seen, nothing timed out
        plan_item(1'b1, fpcd_pkg::OP_POLL, 32'd0, quiet);
        plan_item(1'b1, fpcd_pkg::OP_EDGE, 32'd0, quiet);
        // largest timestamp: both time flags raised, poll changes nothing
        plan_item(1'b1, fpcd_pkg::OP_POLL, 32'hFFFF_FFFF, overdue);
        // inside code on sensor 0, then rotation
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd8500, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd17000, quiet);
        // outside code on sensor 1
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd20800, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd25500, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd29300, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd34000, quiet);
        // inside code one unit off each way on sensor 2
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd42600, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd51000, quiet);
        // two units off, then a gap that saturates and expires the collect time
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd59700, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd359700, quiet);
        plan_item(1'b0, fpcd_pkg::OP_POLL, 32'd359750, quiet);
        // manual mode on sensor 2 with I=2, O=1: both codes finish together
        plan_reg(fpcd_pkg::CFG_MANUAL_SENSOR, 32'd2);
        plan_reg(fpcd_pkg::CFG_INSIDE_UNITS, 32'd2);
        plan_reg(fpcd_pkg::CFG_OUTSIDE_UNITS, 32'd1);
        plan_reg(fpcd_pkg::CFG_MANUAL_MODE, 32'd1);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd359800, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd359900, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd360000, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd360100, quiet);
        // zero unit length
        plan_reg(fpcd_pkg::CFG_UNIT_LENGTH_US, 32'd0);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'd360105, quiet);
        // longest unit, timestamp wrap, zero collect and timeout
        plan_reg(fpcd_pkg::CFG_UNIT_LENGTH_US, 32'd65535);
        plan_reg(fpcd_pkg::CFG_MANUAL_MODE, 32'd0);
        plan_reg(fpcd_pkg::CFG_COLLECT_TIME, 32'd0);
        plan_reg(fpcd_pkg::CFG_TIMEOUT, 32'd0);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'h0000_0010, quiet);
        plan_item(1'b0, fpcd_pkg::OP_POLL, 32'h8000_0000, quiet);
        plan_item(1'b0, fpcd_pkg::OP_EDGE, 32'hFFFF_FFF0, quiet);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[k]) begin
            if (directed_plan[k].is_reg) begin
                settle();
                write_reg(directed_plan[k].reg_idx, directed_plan[k].reg_val);
            end else begin
                push_item(directed_plan[k].it, directed_plan[k].typed, directed_plan[k].known);
            end
        end

        // random phases, each with a full register setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    ins   = fpcd_pkg::RST_INSIDE_UNITS;
                    outs  = fpcd_pkg::RST_OUTSIDE_UNITS;
                    ulen  = fpcd_pkg::RST_UNIT_LENGTH_US;
                    coll  = fpcd_pkg::RST_COLLECT_TIME;
                    tmo   = fpcd_pkg::RST_TIMEOUT;
                    nsig  = fpcd_pkg::RST_NO_SIGNAL;
                    man   = 1'b0;
                    mpick = 2'd0;
                end
                1: begin
                    // shortest unit, rotation on every unmatched edge
                    ins   = 8'd255;
                    outs  = 8'd1;
                    ulen  = 16'd1;
                    coll  = 32'd0;
                    tmo   = 32'd0;
                    nsig  = 32'hFFFF_FFFF;
                    man   = 1'b0;
                    mpick = 2'd3;
                end
                2: begin
                    // outside step negative, manual hold on the last sensor
                    ins   = 8'd1;
                    outs  = 8'd255;
                    ulen  = 16'hFFFF;
                    coll  = 32'hFFFF_FFFF;
                    tmo   = 32'hFFFF_FFFF;
                    nsig  = 32'd0;
                    man   = 1'b1;
                    mpick = 2'd3;
                end
                default: begin
                    ins  = 8'($urandom_range(2, 255));
                    outs = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                       : 8'($urandom_range(1, ins - 1));
                    pick = $urandom_range(0, 19);
                    if (pick == 0) ulen = 16'd0;
                    else if (pick < 3) ulen = 16'($urandom_range(1, 65535));
                    else ulen = 16'($urandom_range(1, 1000));
                    span  = ((ulen == 16'd0) ? 1 : int'(ulen)) * int'(ins) * 4;
                    coll  = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, span);
                    tmo   = $urandom_range(0, span * 6);
                    nsig  = $urandom_range(0, span * 3);
                    man   = ($urandom_range(0, 3) == 0);
                    mpick = 2'($urandom_range(0, 3));
                end
            endcase
            span = ((ulen == 16'd0) ? 1 : int'(ulen)) * int'(ins) * 4;

            settle();
            write_reg(fpcd_pkg::CFG_INSIDE_UNITS, 32'(ins));
            write_reg(fpcd_pkg::CFG_OUTSIDE_UNITS, 32'(outs));
            write_reg(fpcd_pkg::CFG_UNIT_LENGTH_US, 32'(ulen));
            write_reg(fpcd_pkg::CFG_COLLECT_TIME, coll);
            write_reg(fpcd_pkg::CFG_TIMEOUT, tmo);
            write_reg(fpcd_pkg::CFG_NO_SIGNAL, nsig);
            write_reg(fpcd_pkg::CFG_MANUAL_MODE, 32'(man));
            write_reg(fpcd_pkg::CFG_MANUAL_SENSOR, 32'(mpick));

            // some phases run with no idling on either side
            in_idle  = (p != 1 && p != 4);
            out_idle = (p != 1 && p != 4);
            stamp    = $urandom;
            pulse_plan.delete();

            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    stamp       = stamp + $urandom_range(0, 2 * span);
                    item.opcode = fpcd_pkg::OP_POLL;
                end else begin
                    if (pulse_plan.size() == 0) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 40) begin
                            repeat ($urandom_range(2, 3)) pulse_plan.push_back(int'(ins));
                        end else if (pick < 80) begin
                            repeat (2) begin
                                pulse_plan.push_back(int'(outs));
                                pulse_plan.push_back(int'(ins) - int'(outs));
                            end
                        end else if (pick < 92) begin
                            pulse_plan.push_back(int'($urandom_range(0, 300)));
                        end else begin
                            pulse_plan.push_back(LONG_GAP);
                        end
                    end
                    units = pulse_plan.pop_front();
                    pick  = $urandom_range(0, 99);
                    if (units == LONG_GAP) begin
                        if (pick < 50 || coll > 32'hF000_0000) diff = longint'($urandom);
                        else diff = longint'(coll) + longint'($urandom_range(1, 1000));
                    end else if (ulen == 16'd0) begin
                        diff = longint'($urandom_range(0, 1000));
                    end else begin
                        // jitter: mostly exact, some within tolerance, a few outside
                        if (pick >= 95) units = units + (pick[0] ? 2 : -2);
                        else if (pick >= 70) units = units + int'($urandom_range(0, 2)) - 1;
                        if (units < 0) units = 0;
                        // anywhere inside the rounding window of that unit count
                        diff = longint'(units) * longint'(ulen)
                             + longint'($urandom_range(0, ulen - 1)) - longint'(ulen / 2);
                        if (diff < 0) diff = 0;
                    end
                    stamp       = stamp + diff[31:0];
                    item.opcode = fpcd_pkg::OP_EDGE;
                end
                item.now_us = stamp;
                push_item(item, 1'b0, quiet);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/fpcd_pkg.sv
rtl/core/fpcd_ctrl.sv
rtl/core/fpcd_datapath.sv
rtl/core/fence_pulse_code_detector.sv
rtl/core/fpcd_checker.sv
tb/tb_top.sv
